// ===== hdl/afl_pkg.sv =====
`default_nettype none

package afl_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W      = 10;
  localparam int OFF_W       = ADDR_W + 1;
  localparam int SPACE_BYTES = 1 << ADDR_W;
  localparam int NAME_W      = 16;
  localparam int QADDR_W     = 32;

  localparam logic [1:0] MODE_DECLARE   = 2'd0;
  localparam logic [1:0] MODE_FIND_NAME = 2'd1;
  localparam logic [1:0] MODE_FIND_ADDR = 2'd2;

  // size classes: byte, short, int, long
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_SHORT = 2'd1;
  localparam logic [1:0] SZ_INT   = 2'd2;
  localparam logic [1:0] SZ_LONG  = 2'd3;

  localparam logic ERR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } afl_state_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
  } afl_entry_t;

endpackage

`default_nettype wire

// ===== hdl/aligned_field_layout_table.sv =====
// channel  | ports                                             | dir
// input    | in_valid, in_stall, in_mode, in_size_class,       | in (stall out)
//          | in_name_id, in_query_address                      |
// result   | out_valid, out_stall, out_start_offset,           | out (stall in)
//          | out_found_name, out_error                         |
//
// a declare is accepted, then the result moves into the output register.
// a lookup compares the entries up to the hit or the entry count on a miss,
// one per cycle from the one read port; a name miss gives no beat.
// one item at a time; a waiting result holds the block in emit only while the output
// register is still full and stalled, else it moves out and the block returns to idle.
// reset clears entry count, running offset and control; the table is left as it is.
`default_nettype none

module aligned_field_layout_table (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_mode,
  input  wire logic [1:0]                     in_size_class,
  input  wire logic [afl_pkg::NAME_W-1:0]     in_name_id,
  input  wire logic [afl_pkg::QADDR_W-1:0]    in_query_address,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [afl_pkg::ADDR_W-1:0]          out_start_offset,
  output logic [afl_pkg::NAME_W-1:0]          out_found_name,
  output logic                                out_error
);

  afl_pkg::afl_entry_t entry_mem [afl_pkg::MAX_ENTRIES];

  afl_pkg::afl_state_t state_r, state_nxt;
  logic [afl_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [afl_pkg::OFF_W-1:0]   offset_r, offset_nxt;
  logic [afl_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic                        last_r, last_nxt;
  logic [1:0]                  q_mode_r, q_mode_nxt;
  logic [afl_pkg::NAME_W-1:0]  q_name_r, q_name_nxt;
  logic [afl_pkg::QADDR_W-1:0] q_addr_r, q_addr_nxt;

  logic [afl_pkg::ADDR_W-1:0]  res_start_r, res_start_nxt;
  logic [afl_pkg::NAME_W-1:0]  res_name_r, res_name_nxt;
  logic                        res_err_r, res_err_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [afl_pkg::ADDR_W-1:0]  out_start_r, out_start_nxt;
  logic [afl_pkg::NAME_W-1:0]  out_name_r, out_name_nxt;
  logic                        out_err_r, out_err_nxt;

  afl_pkg::afl_entry_t         rd_data_r;
  logic [afl_pkg::IDX_W-1:0]   rd_addr;
  logic                        wr_en;
  logic [afl_pkg::IDX_W-1:0]   wr_addr;
  afl_pkg::afl_entry_t         wr_data;

  logic                        in_take;
  logic [afl_pkg::OFF_W-1:0]   size_m1;
  logic [afl_pkg::OFF_W-1:0]   dcl_start;
  logic [afl_pkg::OFF_W:0]     dcl_end;
  logic                        dcl_refuse;
  logic                        hit;

  assign in_stall = (state_r != afl_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  assign out_valid        = out_valid_r;
  assign out_start_offset = out_start_r;
  assign out_found_name   = out_name_r;
  assign out_error        = out_err_r;

  // round the running offset up to the field size
  assign size_m1   = (afl_pkg::OFF_W'(1) << in_size_class) - afl_pkg::OFF_W'(1);
  assign dcl_start = (offset_r + size_m1) & ~size_m1;
  assign dcl_end   = {1'b0, dcl_start} + {1'b0, size_m1} + (afl_pkg::OFF_W + 1)'(1);
  assign dcl_refuse = (count_r >= afl_pkg::CNT_W'(afl_pkg::MAX_ENTRIES)) ||
                      (dcl_end > (afl_pkg::OFF_W + 1)'(afl_pkg::SPACE_BYTES));

  always_comb begin
    if (q_mode_r == afl_pkg::MODE_FIND_NAME) begin
      hit = (rd_data_r.name == q_name_r);
    end else begin
      hit = (q_addr_r[afl_pkg::QADDR_W-1:afl_pkg::ADDR_W] == '0) &&
            (rd_data_r.first <= q_addr_r[afl_pkg::ADDR_W-1:0]) &&
            (q_addr_r[afl_pkg::ADDR_W-1:0] <= rd_data_r.last);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    offset_nxt    = offset_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    q_mode_nxt    = q_mode_r;
    q_name_nxt    = q_name_r;
    q_addr_nxt    = q_addr_r;
    res_start_nxt = res_start_r;
    res_name_nxt  = res_name_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_start_nxt = out_start_r;
    out_name_nxt  = out_name_r;
    out_err_nxt   = out_err_r;
    rd_addr       = idx_r[afl_pkg::IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = count_r[afl_pkg::IDX_W-1:0];
    wr_data.name  = in_name_id;
    wr_data.first = dcl_start[afl_pkg::ADDR_W-1:0];
    wr_data.last  = dcl_start[afl_pkg::ADDR_W-1:0] + size_m1[afl_pkg::ADDR_W-1:0];

    case (state_r)
      afl_pkg::ST_IDLE: begin
        if (in_take) begin
          q_mode_nxt = in_mode;
          q_name_nxt = in_name_id;
          q_addr_nxt = in_query_address;
          case (in_mode)
            afl_pkg::MODE_DECLARE: begin
              res_name_nxt = '0;
              if (dcl_refuse) begin
                res_start_nxt = '0;
                res_err_nxt   = afl_pkg::ERR;
              end else begin
                wr_en         = 1'b1;
                count_nxt     = count_r + afl_pkg::CNT_W'(1);
                offset_nxt    = dcl_end[afl_pkg::OFF_W-1:0];
                res_start_nxt = dcl_start[afl_pkg::ADDR_W-1:0];
                res_err_nxt   = 1'b0;
              end
              state_nxt = afl_pkg::ST_EMIT;
            end
            afl_pkg::MODE_FIND_NAME, afl_pkg::MODE_FIND_ADDR: begin
              if (count_r == '0) begin
                if (in_mode == afl_pkg::MODE_FIND_ADDR) begin
                  res_start_nxt = '0;
                  res_name_nxt  = '0;
                  res_err_nxt   = afl_pkg::ERR;
                  state_nxt     = afl_pkg::ST_EMIT;
                end
              end else begin
                // entry 0 is read now and compared in the first scan cycle
                rd_addr   = '0;
                idx_nxt   = afl_pkg::CNT_W'(1);
                last_nxt  = (count_r == afl_pkg::CNT_W'(1));
                state_nxt = afl_pkg::ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      afl_pkg::ST_SCAN: begin
        if (hit) begin
          res_err_nxt = 1'b0;
          if (q_mode_r == afl_pkg::MODE_FIND_NAME) begin
            res_start_nxt = rd_data_r.first;
            res_name_nxt  = '0;
          end else begin
            res_start_nxt = '0;
            res_name_nxt  = rd_data_r.name;
          end
          state_nxt = afl_pkg::ST_EMIT;
        end else if (last_r) begin
          if (q_mode_r == afl_pkg::MODE_FIND_ADDR) begin
            res_start_nxt = '0;
            res_name_nxt  = '0;
            res_err_nxt   = afl_pkg::ERR;
            state_nxt     = afl_pkg::ST_EMIT;
          end else begin
            state_nxt = afl_pkg::ST_IDLE;
          end
        end else begin
          idx_nxt  = idx_r + afl_pkg::CNT_W'(1);
          last_nxt = (idx_r == count_r - afl_pkg::CNT_W'(1));
        end
      end
      afl_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_start_nxt = res_start_r;
          out_name_nxt  = res_name_r;
          out_err_nxt   = res_err_r;
          state_nxt     = afl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = afl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= entry_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= afl_pkg::ST_IDLE;
      count_r     <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    last_r      <= last_nxt;
    q_mode_r    <= q_mode_nxt;
    q_name_r    <= q_name_nxt;
    q_addr_r    <= q_addr_nxt;
    res_start_r <= res_start_nxt;
    res_name_r  <= res_name_nxt;
    res_err_r   <= res_err_nxt;
    out_start_r <= out_start_nxt;
    out_name_r  <= out_name_nxt;
    out_err_r   <= out_err_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/afl_checker.sv =====
`default_nettype none

module afl_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [afl_pkg::ADDR_W-1:0]  out_start_offset,
  input wire logic [afl_pkg::NAME_W-1:0]  out_found_name,
  input wire logic                        out_error
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_start_offset) &&
    $stable(out_found_name) && $stable(out_error))
    else $error("stalled result beat changed");

  // error beats carry no offset and no name
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_start_offset == '0 && out_found_name == '0)
    else $error("error beat with payload");

  // a found name never comes with a start offset or an error
  a_name_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_name != '0 |-> out_start_offset == '0 && !out_error)
    else $error("found name beat with offset or error");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind aligned_field_layout_table afl_checker u_afl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_start_offset (out_start_offset),
  .out_found_name   (out_found_name),
  .out_error        (out_error)
);

`default_nettype wire

// ===== tb/aligned_field_layout_table_test.sv =====
module aligned_field_layout_table_test;
  import afl_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 2000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         size_class;
    logic [NAME_W-1:0]  name_id;
    logic [QADDR_W-1:0] query_address;
  } field_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start_offset;
    logic [NAME_W-1:0] found_name;
    logic              error;
  } layout_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic [1:0] in_size_class = '0;
  logic [NAME_W-1:0] in_name_id = '0;
  logic [QADDR_W-1:0] in_query_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ADDR_W-1:0] out_start_offset;
  logic [NAME_W-1:0] out_found_name;
  logic out_error;

  aligned_field_layout_table i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_size_class    (in_size_class),
    .in_name_id       (in_name_id),
    .in_query_address (in_query_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_start_offset (out_start_offset),
    .out_found_name   (out_found_name),
    .out_error        (out_error)
  );

  // shadow of the layout table
  logic [NAME_W-1:0] tbl_name [MAX_ENTRIES];
  logic [ADDR_W-1:0] tbl_first [MAX_ENTRIES];
  logic [ADDR_W-1:0] tbl_last [MAX_ENTRIES];
  int tbl_count = 0;
  int tbl_next = 0;

  field_req_t pending_reqs[$];
  layout_resp_t layout_expected[$];

  int in_beats = 0;
  int out_beats = 0;
  int drv_seen = 0;
  int rx_seen = 0;
  int gap_left = 0;
  int rx_wait = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit in_flight;
  int fail_count = 0;
  int idle_cycles = 0;

  int n_declared = 0;
  int n_refused = 0;
  int n_name_hit = 0;
  int n_name_miss = 0;
  int n_addr_hit = 0;
  int n_addr_miss = 0;

  field_req_t taken_req;
  layout_resp_t want_resp;
  layout_resp_t got_resp;
  layout_resp_t new_resp;

  initial begin
    forever #10 clk = ~clk;
  end

  // returns 1 when the item produces a result beat
  function automatic bit layout_step(input field_req_t req, output layout_resp_t resp);
    int size;
    int start;
    resp = '0;
    case (req.mode)
      MODE_DECLARE: begin
        size = 1 << req.size_class;
        start = (tbl_next + size - 1) & ~(size - 1);
        if (tbl_count >= MAX_ENTRIES || start + size > SPACE_BYTES) begin
          resp.error = ERR;
          n_refused++;
          return 1'b1;
        end
        tbl_name[tbl_count] = req.name_id;
        tbl_first[tbl_count] = ADDR_W'(start);
        tbl_last[tbl_count] = ADDR_W'(start + size - 1);
        tbl_count++;
        tbl_next = start + size;
        resp.start_offset = ADDR_W'(start);
        n_declared++;
        return 1'b1;
      end
      MODE_FIND_NAME: begin
        // oldest entry wins on duplicate names
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_name[i] == req.name_id) begin
            resp.start_offset = tbl_first[i];
            n_name_hit++;
            return 1'b1;
          end
        end
        n_name_miss++;
        return 1'b0;
      end
      MODE_FIND_ADDR: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (req.query_address >= QADDR_W'(tbl_first[i]) &&
              req.query_address <= QADDR_W'(tbl_last[i])) begin
            resp.found_name = tbl_name[i];
            n_addr_hit++;
            return 1'b1;
          end
        end
        resp.error = ERR;
        n_addr_miss++;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic queue_req(input logic [1:0] mode, input logic [1:0] size_class,
                           input logic [NAME_W-1:0] name_id,
                           input logic [QADDR_W-1:0] query_address);
    field_req_t req;
    req.mode = mode;
    req.size_class = size_class;
    req.name_id = name_id;
    req.query_address = query_address;
    pending_reqs.push_back(req);
  endtask

  // driver: one beat in flight, random gap before each new one
  always @(negedge clk) begin
    if (rst_n) begin
      in_flight = in_valid && (in_beats == drv_seen);
      drv_seen = in_beats;
      if (!in_flight) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          taken_req = pending_reqs.pop_front();
          in_mode <= taken_req.mode;
          in_size_class <= taken_req.size_class;
          in_name_id <= taken_req.name_id;
          in_query_address <= taken_req.query_address;
          in_valid <= 1'b1;
          if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
          gap_left = tx_calm ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side stall, redrawn after every accepted beat
  always @(negedge clk) begin
    if (rx_seen != out_beats) begin
      rx_seen = out_beats;
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 19);
    end
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check result beats, then predict from the accepted input beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        out_beats++;
        got_resp.start_offset = out_start_offset;
        got_resp.found_name = out_found_name;
        got_resp.error = out_error;
        if (layout_expected.size() == 0) begin
          $error("unexpected result beat: start_offset %0d found_name %0d error %0d",
                 out_start_offset, out_found_name, out_error);
          fail_count++;
        end else begin
          want_resp = layout_expected.pop_front();
          if (got_resp.start_offset !== want_resp.start_offset) begin
            $error("start_offset: expected %0d, actual %0d",
                   want_resp.start_offset, got_resp.start_offset);
            fail_count++;
          end
          if (got_resp.found_name !== want_resp.found_name) begin
            $error("found_name: expected %0d, actual %0d",
                   want_resp.found_name, got_resp.found_name);
            fail_count++;
          end
          if (got_resp.error !== want_resp.error) begin
            $error("error: expected %0d, actual %0d", want_resp.error, got_resp.error);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_beats++;
        if (layout_step({in_mode, in_size_class, in_name_id, in_query_address}, new_resp))
          layout_expected.push_back(new_resp);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int counted;
    int pick;
    int extent;
    logic [NAME_W-1:0] used_names[$];
    field_req_t req;

    // empty table, then a small layout with padding and a duplicate name
    queue_req(MODE_FIND_NAME, SZ_BYTE, 16'h0000, '0);
    queue_req(MODE_FIND_ADDR, SZ_BYTE, 16'h0000, 32'd0);
    queue_req(MODE_DECLARE, SZ_BYTE, 16'h0000, '0);
    queue_req(MODE_DECLARE, SZ_LONG, 16'hFFFF, '0);
    queue_req(MODE_DECLARE, SZ_SHORT, 16'h1234, '0);
    queue_req(MODE_DECLARE, SZ_INT, 16'h1234, '0);
    queue_req(MODE_DECLARE, SZ_BYTE, 16'hABCD, '0);
    queue_req(MODE_DECLARE, SZ_INT, 16'h5555, '0);
    queue_req(MODE_DECLARE, SZ_LONG, 16'hAAAA, '0);
    queue_req(MODE_FIND_NAME, SZ_BYTE, 16'h1234, '0);
    queue_req(MODE_FIND_NAME, SZ_BYTE, 16'hFFFF, '0);
    queue_req(MODE_FIND_NAME, SZ_BYTE, 16'h0000, '0);
    queue_req(MODE_FIND_NAME, SZ_BYTE, 16'h7777, '0);
    queue_req(MODE_FIND_ADDR, SZ_BYTE, 16'h0000, 32'd0);
    queue_req(MODE_FIND_ADDR, SZ_BYTE, 16'h0000, 32'd3);
    queue_req(MODE_FIND_ADDR, SZ_BYTE, 16'h0000, 32'd15);
    queue_req(MODE_FIND_ADDR, SZ_BYTE, 16'h0000, 32'd17);
    queue_req(MODE_FIND_ADDR, SZ_BYTE, 16'h0000, 32'd23);
    queue_req(MODE_FIND_ADDR, SZ_BYTE, 16'h0000, 32'd39);
    queue_req(MODE_FIND_ADDR, SZ_BYTE, 16'h0000, 32'd40);
    queue_req(MODE_FIND_ADDR, SZ_BYTE, 16'h0000, 32'd1023);
    queue_req(MODE_FIND_ADDR, SZ_BYTE, 16'h0000, 32'd1024);
    queue_req(MODE_FIND_ADDR, SZ_BYTE, 16'h0000, 32'hFFFF_FFFF);
    queue_req(MODE_UNUSED, SZ_LONG, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(MODE_UNUSED, SZ_BYTE, 16'h0000, 32'd0);
    used_names = '{16'h0000, 16'hFFFF, 16'h1234, 16'hABCD, 16'h5555, 16'hAAAA};
    extent = 40;

    // declares are sparse so the table fills late and refusals show up near the end
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      req.size_class = 2'($urandom);
      req.name_id = NAME_W'($urandom);
      req.query_address = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 9) begin
        req.mode = MODE_DECLARE;
        if ($urandom_range(0, 3) == 0)
          req.name_id = used_names[$urandom_range(0, used_names.size() - 1)];
        used_names.push_back(req.name_id);
        extent = (extent + 8 > SPACE_BYTES - 1) ? SPACE_BYTES - 1 : extent + 8;
        counted++;
      end else if (pick < 45) begin
        req.mode = MODE_FIND_NAME;
        if ($urandom_range(0, 9) < 7)
          req.name_id = used_names[$urandom_range(0, used_names.size() - 1)];
        counted++;
      end else if (pick < 95) begin
        req.mode = MODE_FIND_ADDR;
        pick = $urandom_range(0, 9);
        if (pick < 8) req.query_address = $urandom_range(0, extent);
        else if (pick == 8) req.query_address = $urandom_range(0, SPACE_BYTES - 1);
        counted++;
      end else begin
        req.mode = MODE_UNUSED;
      end
      pending_reqs.push_back(req);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (layout_expected.size() != 0) @(posedge clk);
    // a trailing name miss may still be scanning
    repeat (2 * MAX_ENTRIES + 20) @(posedge clk);

    $display("%0d beats in: %0d fields laid out, %0d declares refused on a full table",
             in_beats, n_declared, n_refused);
    $display("name lookups %0d hit / %0d miss, address lookups %0d hit / %0d uncovered",
             n_name_hit, n_name_miss, n_addr_hit, n_addr_miss);
    if (fail_count == 0 && layout_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
